// ===== design/mfat_pkg.sv =====
// Shared types, constants and coefficient tables for the motor feedback angle tracker.
// Used by mfat_angle_pipe and motor_feedback_angle_tracker; depends on nothing else.

package mfat_pkg;

    // Encoder geometry: one mechanical turn of the rotor encoder.
    localparam int COUNTS_PER_TURN = 8192;
    localparam int POS_W           = 13;

    localparam logic [POS_W-1:0]  POS_MAX   = POS_W'(COUNTS_PER_TURN - 1);
    localparam logic signed [14:0] FULL_TURN = 15'(COUNTS_PER_TURN);
    localparam logic signed [14:0] HALF_TURN = 15'(COUNTS_PER_TURN / 2);

    // Register indexes of the configuration port.
    localparam logic CFG_FRAME_ID   = 1'b0;
    localparam logic CFG_MOTOR_KIND = 1'b1;

    localparam logic [10:0] FRAME_ID_RESET = 11'd513;

    typedef enum logic [1:0] {
        KIND_DIRECT = 2'd0,   // ratio 1
        KIND_R36    = 2'd1,   // ratio 36
        KIND_R3591  = 2'd2,   // ratio 3591/187
        KIND_R19    = 2'd3    // ratio 19
    } motor_kind_t;

    typedef struct packed {
        logic [10:0] rx_id;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
    } frame_t;

    typedef struct packed {
        logic [7:0]         temperature;
        logic [POS_W-1:0]   position;
        logic signed [15:0] speed;
        logic signed [15:0] torque_current;
        logic signed [31:0] total_counts;
        logic signed [47:0] angle_q16;
    } result_t;

    // One accumulated frame on its way through the angle scaling pipeline.
    typedef struct packed {
        result_t     res;
        logic [31:0] mag;
        logic        neg;
        motor_kind_t kind;
    } scale_item_t;

    // The angle is round(|counts| * k / d). With mag = d*h + r the quotient splits into
    // k*h + floor((k*r + half) / d). m1 is the reciprocal of d for a 32-bit dividend,
    // m2 the reciprocal of d (shift 34) for the small remainder term.
    typedef struct packed {
        logic [15:0] k;
        logic [8:0]  d;
        logic [8:0]  half;
        logic [32:0] m1;
        logic [29:0] m2;
    } coef_t;

    function automatic coef_t kind_coef(motor_kind_t kind);
        coef_t c;
        case (kind)
            KIND_DIRECT: c = '{k: 16'd2880,  d: 9'd1,   half: 9'd0,
                               m1: 33'h1_0000_0000, m2: 30'd0};
            KIND_R36:    c = '{k: 16'd80,    d: 9'd1,   half: 9'd0,
                               m1: 33'h1_0000_0000, m2: 30'd0};
            KIND_R3591:  c = '{k: 16'd59840, d: 9'd399, half: 9'd199,
                               m1: 33'd5511336481,  m2: 30'd43057317};
            KIND_R19:    c = '{k: 16'd2880,  d: 9'd19,  half: 9'd9,
                               m1: 33'd7233629131,  m2: 30'd904203642};
            default:     c = '{k: 16'd2880,  d: 9'd1,   half: 9'd0,
                               m1: 33'h1_0000_0000, m2: 30'd0};
        endcase
        return c;
    endfunction

endpackage

// ===== design/mfat_angle_pipe.sv =====
// Angle scaling pipeline: turns an accumulated count magnitude into Q16 output degrees.
// Five register stages with per-stage flow control; depends on mfat_pkg.

module mfat_angle_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 acc_valid,
    output logic                 acc_stall,
    input  mfat_pkg::scale_item_t acc_item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output mfat_pkg::result_t    result
);

    // Stage valid flags.
    logic quo_v_reg, rem_v_reg, num_v_reg, frac_v_reg, out_v_reg;

    // Stage payloads.
    mfat_pkg::scale_item_t quo_item_reg, rem_item_reg, num_item_reg, frac_item_reg;
    logic [31:0] quo_h_reg;
    logic [8:0]  rem_r_reg;
    logic [47:0] rem_kh_reg, num_kh_reg, frac_kh_reg;
    logic [24:0] num_t_reg;
    logic [15:0] frac_q_reg;
    mfat_pkg::result_t out_res_reg;

    // A stage is free when it is empty or its content moves on this cycle.
    logic out_free, frac_free, num_free, rem_free, quo_free;

    assign out_free  = !out_v_reg  || !result_stall;
    assign frac_free = !frac_v_reg || out_free;
    assign num_free  = !num_v_reg  || frac_free;
    assign rem_free  = !rem_v_reg  || num_free;
    assign quo_free  = !quo_v_reg  || rem_free;
    assign acc_stall = !quo_free;

    // Quotient by reciprocal multiplication.
    mfat_pkg::coef_t quo_c, rem_c, num_c, frac_c;
    logic [64:0] quo_prod;
    logic [31:0] quo_h_next;

    assign quo_c    = mfat_pkg::kind_coef(acc_item.kind);
    assign quo_prod = 65'(acc_item.mag) * 65'(quo_c.m1);

    always_comb
    begin
        case (acc_item.kind)
            mfat_pkg::KIND_R3591: quo_h_next = 32'(quo_prod[64:41]);
            mfat_pkg::KIND_R19:   quo_h_next = 32'(quo_prod[64:37]);
            default:              quo_h_next = quo_prod[63:32];
        endcase
    end

    // Remainder and the whole-quotient product.
    logic [40:0] rem_dh;
    logic [31:0] rem_full;

    assign rem_c    = mfat_pkg::kind_coef(quo_item_reg.kind);
    assign rem_dh   = 41'(quo_h_reg) * 41'(rem_c.d);
    assign rem_full = quo_item_reg.mag - rem_dh[31:0];

    // Rounded numerator of the remainder term.
    assign num_c = mfat_pkg::kind_coef(rem_item_reg.kind);

    // Remainder term divided by the same divisor.
    logic [54:0] frac_prod;

    assign frac_c    = mfat_pkg::kind_coef(num_item_reg.kind);
    assign frac_prod = 55'(num_t_reg) * 55'(frac_c.m2);

    // Final sum and sign. The magnitude never exceeds 2^47, so no clamp is needed.
    logic [47:0] out_q;
    mfat_pkg::result_t out_res_next;

    always_comb
    begin
        out_q        = frac_kh_reg + 48'(frac_q_reg);
        out_res_next = frac_item_reg.res;
        out_res_next.angle_q16 = frac_item_reg.neg ? signed'(48'(0) - out_q) : signed'(out_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_v_reg  <= 1'b0;
            rem_v_reg  <= 1'b0;
            num_v_reg  <= 1'b0;
            frac_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (quo_free)  quo_v_reg  <= acc_valid;
            if (rem_free)  rem_v_reg  <= quo_v_reg;
            if (num_free)  num_v_reg  <= rem_v_reg;
            if (frac_free) frac_v_reg <= num_v_reg;
            if (out_free)  out_v_reg  <= frac_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (quo_free && acc_valid)
        begin
            quo_item_reg <= acc_item;
            quo_h_reg    <= quo_h_next;
        end
        if (rem_free && quo_v_reg)
        begin
            rem_item_reg <= quo_item_reg;
            rem_r_reg    <= rem_full[8:0];
            rem_kh_reg   <= 48'(quo_h_reg) * 48'(rem_c.k);
        end
        if (num_free && rem_v_reg)
        begin
            num_item_reg <= rem_item_reg;
            num_kh_reg   <= rem_kh_reg;
            num_t_reg    <= 25'(rem_r_reg) * 25'(num_c.k) + 25'(num_c.half);
        end
        if (frac_free && num_v_reg)
        begin
            frac_item_reg <= num_item_reg;
            frac_kh_reg   <= num_kh_reg;
            frac_q_reg    <= frac_prod[49:34];
        end
        if (out_free && frac_v_reg)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign result_valid = out_v_reg;
    assign result       = out_res_reg;

endmodule

// ===== design/motor_feedback_angle_tracker.sv =====
// Top level of the motor feedback angle tracker: frame filter, encoder unwrap and output.
// Depends on mfat_pkg and mfat_angle_pipe.

// The tracker takes one received feedback frame per request on the frame channel and
// returns one result per frame whose identifier equals the frame_id register; other
// frames are taken and dropped silently. It sustains one frame per clock cycle while
// nothing stalls. A result passes the input register, the unwrap stage and the quotient,
// remainder, numerator and fraction registers of the angle scaling pipeline before its
// output register. The rate is set by the unwrap stage, whose turn-count accumulator is
// a feedback loop through a single register; the angle scaling is a pipeline of
// reciprocal multiplications that holds up the flow only when the result is stalled.
// Each stage holds its item only while the stage after it is full and stalled, so
// bubbles close up and new frames keep entering while a finished result waits. The
// first matching frame after reset only records the encoder position and reports zero
// counts. Configuration registers (frame_id, motor_kind) must be written only while the
// block is idle. The reported angle is not wrapped; it follows the accumulated count.

module motor_feedback_angle_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [10:0]       cfg_data,
    input  logic              frame_valid,
    output logic              frame_stall,
    input  mfat_pkg::frame_t  frame,
    output logic              result_valid,
    input  logic              result_stall,
    output mfat_pkg::result_t result
);

    // Configuration registers.
    logic [10:0]           frame_id_reg;
    mfat_pkg::motor_kind_t motor_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_id_reg   <= mfat_pkg::FRAME_ID_RESET;
            motor_kind_reg <= mfat_pkg::KIND_R3591;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mfat_pkg::CFG_FRAME_ID:   frame_id_reg   <= cfg_data;
                mfat_pkg::CFG_MOTOR_KIND: motor_kind_reg <= mfat_pkg::motor_kind_t'(cfg_data[1:0]);
                default:                  frame_id_reg   <= frame_id_reg;
            endcase
        end
    end

    // Flow control between the input register, the unwrap stage and the angle pipeline.
    logic acc_v_reg;
    logic in_v_reg;
    logic pipe_stall;
    logic acc_free, in_free;

    assign acc_free    = !acc_v_reg || !pipe_stall;
    assign in_free     = !in_v_reg  || acc_free;
    assign frame_stall = !in_free;

    // Input register. Frames with a foreign identifier are taken but never marked valid.
    mfat_pkg::frame_t in_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_free)
        begin
            in_v_reg <= frame_valid && (frame.rx_id == frame_id_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && frame_valid)
        begin
            in_frame_reg <= frame;
        end
    end

    // Unwrap stage: big-endian unpack, saturation and shortest-path delta accumulation.
    logic                       seen_first_reg;
    logic [mfat_pkg::POS_W-1:0] last_pos_reg;
    logic signed [31:0]         count_sum_reg;

    logic [15:0]                enc;
    logic [mfat_pkg::POS_W-1:0] pos;
    logic signed [14:0]         delta;
    logic signed [14:0]         step;
    logic signed [31:0]         count_next;
    mfat_pkg::scale_item_t      acc_item_next;
    mfat_pkg::scale_item_t      acc_item_reg;

    always_comb
    begin
        enc = {in_frame_reg.byte0, in_frame_reg.byte1};
        pos = (enc > 16'(mfat_pkg::POS_MAX)) ? mfat_pkg::POS_MAX : enc[mfat_pkg::POS_W-1:0];

        delta = signed'({2'b00, pos}) - signed'({2'b00, last_pos_reg});
        step  = delta;

        // The direct-drive kind folds an exact half turn; the geared kinds keep it.
        if (motor_kind_reg == mfat_pkg::KIND_DIRECT)
        begin
            if (delta >= mfat_pkg::HALF_TURN)
                step = delta - mfat_pkg::FULL_TURN;
            else if (delta <= -mfat_pkg::HALF_TURN)
                step = delta + mfat_pkg::FULL_TURN;
        end
        else
        begin
            if (delta > mfat_pkg::HALF_TURN)
                step = delta - mfat_pkg::FULL_TURN;
            else if (delta < -mfat_pkg::HALF_TURN)
                step = delta + mfat_pkg::FULL_TURN;
        end

        // The first frame only anchors the position.
        count_next = seen_first_reg ? count_sum_reg + 32'(step) : 32'sd0;

        acc_item_next.res.temperature    = in_frame_reg.byte6;
        acc_item_next.res.position       = pos;
        acc_item_next.res.speed          = signed'({in_frame_reg.byte2, in_frame_reg.byte3});
        acc_item_next.res.torque_current = signed'({in_frame_reg.byte4, in_frame_reg.byte5});
        acc_item_next.res.total_counts   = count_next;
        acc_item_next.res.angle_q16      = 48'sd0;
        acc_item_next.neg  = count_next[31];
        acc_item_next.mag  = count_next[31] ? 32'(0) - unsigned'(count_next)
                                            : unsigned'(count_next);
        acc_item_next.kind = motor_kind_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_v_reg      <= 1'b0;
            seen_first_reg <= 1'b0;
            last_pos_reg   <= '0;
            count_sum_reg  <= 32'sd0;
        end
        else if (acc_free)
        begin
            acc_v_reg <= in_v_reg;
            if (in_v_reg)
            begin
                seen_first_reg <= 1'b1;
                last_pos_reg   <= pos;
                count_sum_reg  <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_free && in_v_reg)
        begin
            acc_item_reg <= acc_item_next;
        end
    end

    // Angle scaling and output register.
    mfat_angle_pipe u_angle_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc_valid    (acc_v_reg),
        .acc_stall    (pipe_stall),
        .acc_item     (acc_item_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
